@@ rtl/smf_pkg.sv @@
// ============================================================================
// smf_pkg
// Shared types for the sliding mode filter: controller states, output source
// select, and the command and status groups between controller and datapath.
// ============================================================================
package smf_pkg;

    localparam int CODE_W = 8;
    localparam int SIZE_W = 5;
    localparam logic [SIZE_W-1:0] WINDOW_SIZE_RESET = 5'd9;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_PASS,
        S_SCAN,
        S_DRAIN,
        S_BEST,
        S_CRD,
        S_CTR,
        S_FINIT,
        S_FRD,
        S_FEMIT
    } state_t;

    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_BEST,
        SRC_CENTER,
        SRC_FLUSH
    } src_t;

    typedef struct packed {
        logic accept;
        logic scan_rd;
        logic rd_center;
        logic flush_init;
        logic flush_rd;
        logic flush_dec;
        logic out_load;
        src_t src;
    } cmd_t;

    typedef struct packed {
        logic hf_zero;
        logic need_center;
        logic full_window;
        logic in_last;
        logic scan_done;
        logic pipe_busy;
        logic out_free;
        logic flush_done;
    } sts_t;

endpackage

@@ rtl/smf_ctrl.sv @@
// ============================================================================
// smf_ctrl
// Sequencer for the sliding mode filter: accepts a word, then steps the
// datapath through pass-through, window scan, center read and flush.
// ============================================================================
module smf_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  smf_pkg::sts_t sts,
    output smf_pkg::cmd_t cmd
);

    smf_pkg::state_t state_reg;
    smf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            smf_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = smf_pkg::S_DECIDE;
                end
            end
            smf_pkg::S_DECIDE:
            begin
                if (sts.hf_zero)
                begin
                    state_next = smf_pkg::S_PASS;
                end
                else if (sts.need_center)
                begin
                    state_next = sts.full_window ? smf_pkg::S_SCAN : smf_pkg::S_CRD;
                end
                else if (sts.in_last)
                begin
                    state_next = smf_pkg::S_FINIT;
                end
                else
                begin
                    state_next = smf_pkg::S_IDLE;
                end
            end
            smf_pkg::S_PASS:
            begin
                if (sts.out_free)
                begin
                    state_next = smf_pkg::S_IDLE;
                end
            end
            smf_pkg::S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = smf_pkg::S_DRAIN;
                end
            end
            smf_pkg::S_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = smf_pkg::S_BEST;
                end
            end
            smf_pkg::S_BEST, smf_pkg::S_CTR:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.in_last ? smf_pkg::S_FINIT : smf_pkg::S_IDLE;
                end
            end
            smf_pkg::S_CRD:
            begin
                state_next = smf_pkg::S_CTR;
            end
            smf_pkg::S_FINIT:
            begin
                state_next = smf_pkg::S_FRD;
            end
            smf_pkg::S_FRD:
            begin
                state_next = smf_pkg::S_FEMIT;
            end
            smf_pkg::S_FEMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.flush_done ? smf_pkg::S_IDLE : smf_pkg::S_FRD;
                end
            end
            default:
            begin
                state_next = smf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.src = smf_pkg::SRC_INPUT;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            smf_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.accept = s_axis_tvalid;
            end
            smf_pkg::S_PASS:
            begin
                cmd.out_load = sts.out_free;
                cmd.src = smf_pkg::SRC_INPUT;
            end
            smf_pkg::S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
            end
            smf_pkg::S_BEST:
            begin
                cmd.out_load = sts.out_free;
                cmd.src = smf_pkg::SRC_BEST;
            end
            smf_pkg::S_CRD:
            begin
                cmd.rd_center = 1'b1;
            end
            smf_pkg::S_CTR:
            begin
                cmd.out_load = sts.out_free;
                cmd.src = smf_pkg::SRC_CENTER;
            end
            smf_pkg::S_FINIT:
            begin
                cmd.flush_init = 1'b1;
            end
            smf_pkg::S_FRD:
            begin
                cmd.flush_rd = 1'b1;
            end
            smf_pkg::S_FEMIT:
            begin
                cmd.out_load = sts.out_free;
                cmd.src = smf_pkg::SRC_FLUSH;
                cmd.flush_dec = sts.out_free & ~sts.flush_done;
            end
            smf_pkg::S_DECIDE, smf_pkg::S_DRAIN:
            begin
                cmd.accept = 1'b0;
            end
            default:
            begin
                cmd.accept = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/smf_datapath.sv @@
// ============================================================================
// smf_datapath
// Window line memory, histogram memory with per-class valid bits, mode
// tracking, flush counter and output register of the sliding mode filter.
// ============================================================================
module smf_datapath #(
    parameter int NUM_CLASSES     = 16,
    parameter int MAX_HALF_WINDOW = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [smf_pkg::SIZE_W-1:0]  cfg_data,
    input  logic [smf_pkg::CODE_W-1:0]  in_code,
    input  logic                        in_last,
    input  smf_pkg::cmd_t               cmd,
    output smf_pkg::sts_t               sts,
    output logic [smf_pkg::CODE_W-1:0]  out_code,
    output logic                        out_last,
    output logic                        out_valid,
    input  logic                        out_ready
);

    localparam int LINE_DEPTH = 2 * MAX_HALF_WINDOW + 1;
    localparam int OW  = $clog2(LINE_DEPTH);
    localparam int BW  = $clog2(LINE_DEPTH + 1);
    localparam int HW  = $clog2(MAX_HALF_WINDOW + 1);
    localparam int CIW = $clog2(NUM_CLASSES);
    localparam int CW  = BW;

    logic [smf_pkg::SIZE_W-1:0] ws_reg;
    logic [smf_pkg::CODE_W-1:0] line_mem [LINE_DEPTH];
    logic [CW-1:0]              cnt_mem  [NUM_CLASSES];

    logic [OW-1:0]  wp_reg;
    logic [OW-1:0]  wp_next;
    logic [BW-1:0]  bins_reg;
    logic [OW-1:0]  k_reg;
    logic [OW-1:0]  fc_reg;
    logic [smf_pkg::CODE_W-1:0] in_code_reg;
    logic           in_last_reg;
    logic [smf_pkg::CODE_W-1:0] rd_data_reg;
    logic           b_vld_reg;
    logic           c_vld_reg;
    logic [CIW-1:0] c_code_reg;
    logic [CW-1:0]  cnt_rd_reg;
    logic [NUM_CLASSES-1:0] cls_valid_reg;
    logic           f_vld_reg;
    logic [CIW-1:0] f_code_reg;
    logic [CW-1:0]  f_val_reg;
    logic [CIW-1:0] best_class_reg;
    logic [CW-1:0]  best_count_reg;
    logic [smf_pkg::CODE_W-1:0] out_code_reg;
    logic           out_last_reg;
    logic           out_valid_reg;

    logic [3:0]     ws_half;
    logic [HW-1:0]  hf;
    logic [OW-1:0]  two_hf;
    logic [OW-1:0]  scan_half;
    logic [OW-1:0]  scan_off;
    logic [OW-1:0]  rd_off;
    logic [OW-1:0]  rd_addr;
    logic [OW:0]    wrap_addr;
    logic           rd_en;
    logic           line_we;
    logic [BW-1:0]  held;
    logic           code_ok;
    logic [CW-1:0]  cnt_eff;
    logic [CW-1:0]  cnt_new;
    logic           out_free;
    logic [smf_pkg::CODE_W-1:0] load_code;
    logic           load_last;

    // half window, saturated at MAX_HALF_WINDOW
    assign ws_half = ws_reg[smf_pkg::SIZE_W-1:1];
    assign hf = (32'(ws_half) > MAX_HALF_WINDOW) ? HW'(MAX_HALF_WINDOW) : HW'(ws_half);
    assign two_hf = OW'({hf, 1'b0});

    // scan order: offsets 0, 2hf, 1, 2hf-1, ... , hf
    assign scan_half = k_reg >> 1;
    assign scan_off = k_reg[0] ? (two_hf - scan_half) : scan_half;

    assign rd_en = cmd.scan_rd | cmd.rd_center | cmd.flush_rd;

    always_comb
    begin
        if (cmd.scan_rd)
        begin
            rd_off = scan_off;
        end
        else if (cmd.rd_center)
        begin
            rd_off = OW'(hf);
        end
        else
        begin
            rd_off = fc_reg;
        end
    end

    assign wrap_addr = {1'b0, wp_reg} + (OW + 1)'(LINE_DEPTH) - {1'b0, rd_off};
    assign rd_addr = (wp_reg >= rd_off) ? (wp_reg - rd_off) : wrap_addr[OW-1:0];

    assign wp_next = (32'(wp_reg) == LINE_DEPTH - 1) ? '0 : wp_reg + OW'(1);
    assign line_we = cmd.accept & (hf != '0);

    assign held = (bins_reg < BW'(hf)) ? bins_reg : BW'(hf);

    assign code_ok = 32'(rd_data_reg) < NUM_CLASSES;

    // forward the previous cycle's count write, the memory read missed it
    always_comb
    begin
        if (f_vld_reg && (f_code_reg == c_code_reg))
        begin
            cnt_eff = f_val_reg;
        end
        else if (cls_valid_reg[c_code_reg])
        begin
            cnt_eff = cnt_rd_reg;
        end
        else
        begin
            cnt_eff = '0;
        end
    end
    assign cnt_new = cnt_eff + CW'(1);

    assign out_free = ~out_valid_reg | out_ready;

    always_comb
    begin
        load_code = in_code_reg;
        load_last = 1'b0;
        unique case (cmd.src)
            smf_pkg::SRC_INPUT:
            begin
                load_code = in_code_reg;
                load_last = in_last_reg;
            end
            smf_pkg::SRC_BEST:
            begin
                load_code = smf_pkg::CODE_W'(best_class_reg);
                load_last = 1'b0;
            end
            smf_pkg::SRC_CENTER:
            begin
                load_code = rd_data_reg;
                load_last = 1'b0;
            end
            smf_pkg::SRC_FLUSH:
            begin
                load_code = rd_data_reg;
                load_last = (fc_reg == '0);
            end
            default:
            begin
                load_code = in_code_reg;
                load_last = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[wp_next] <= in_code;
        end
        if (rd_en)
        begin
            rd_data_reg <= line_mem[rd_addr];
        end
        if (c_vld_reg)
        begin
            cnt_mem[c_code_reg] <= cnt_new;
        end
        if (b_vld_reg)
        begin
            cnt_rd_reg <= cnt_mem[rd_data_reg[CIW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            in_code_reg <= in_code;
            in_last_reg <= in_last;
        end
        c_code_reg <= rd_data_reg[CIW-1:0];
        f_code_reg <= c_code_reg;
        f_val_reg  <= cnt_new;
        if (cmd.out_load)
        begin
            out_code_reg <= load_code;
            out_last_reg <= load_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg         <= smf_pkg::WINDOW_SIZE_RESET;
            wp_reg         <= '0;
            bins_reg       <= '0;
            k_reg          <= '0;
            fc_reg         <= '0;
            b_vld_reg      <= 1'b0;
            c_vld_reg      <= 1'b0;
            f_vld_reg      <= 1'b0;
            cls_valid_reg  <= '0;
            best_class_reg <= '0;
            best_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ws_reg <= cfg_data;
            end

            if (cmd.accept)
            begin
                k_reg          <= '0;
                cls_valid_reg  <= '0;
                best_class_reg <= '0;
                best_count_reg <= '0;
                if (hf == '0)
                begin
                    bins_reg <= '0;
                end
                else
                begin
                    wp_reg <= wp_next;
                    if (32'(bins_reg) < LINE_DEPTH)
                    begin
                        bins_reg <= bins_reg + BW'(1);
                    end
                end
            end
            else if (cmd.flush_init)
            begin
                bins_reg <= '0;
            end

            if (cmd.scan_rd)
            begin
                k_reg <= k_reg + OW'(1);
            end

            if (cmd.flush_init)
            begin
                fc_reg <= OW'(held - BW'(1));
            end
            else if (cmd.flush_dec)
            begin
                fc_reg <= fc_reg - OW'(1);
            end

            // histogram pipeline: line read, count read, count update
            b_vld_reg <= cmd.scan_rd;
            c_vld_reg <= b_vld_reg & code_ok;
            f_vld_reg <= c_vld_reg & ~cmd.accept;

            if (c_vld_reg)
            begin
                cls_valid_reg[c_code_reg] <= 1'b1;
                if (cnt_new >= best_count_reg)
                begin
                    best_class_reg <= c_code_reg;
                    best_count_reg <= cnt_new;
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.hf_zero     = (hf == '0);
    assign sts.need_center = (bins_reg > BW'(hf));
    assign sts.full_window = (bins_reg >= BW'(two_hf) + BW'(1));
    assign sts.in_last     = in_last_reg;
    assign sts.scan_done   = (k_reg == two_hf);
    assign sts.pipe_busy   = b_vld_reg | c_vld_reg;
    assign sts.out_free    = out_free;
    assign sts.flush_done  = (fc_reg == '0);

    assign out_code  = out_code_reg;
    assign out_last  = out_last_reg;
    assign out_valid = out_valid_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register loaded while a word is still pending");

    a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> (!b_vld_reg && !c_vld_reg))
        else $error("new word accepted while the histogram pipeline is busy");

    a_class_marked: assert property (@(posedge clk) disable iff (!rst_n)
        c_vld_reg |=> cls_valid_reg[$past(c_code_reg)])
        else $error("counted class not marked valid");

    a_best_grows: assert property (@(posedge clk) disable iff (!rst_n)
        c_vld_reg |=> (best_count_reg >= $past(best_count_reg)))
        else $error("mode count dropped during a scan");

endmodule

@@ rtl/sliding_mode_filter.sv @@
// ============================================================================
// sliding_mode_filter
// Sliding-window mode filter over the bins of one radial of class codes.
// ============================================================================
// Bins enter one word at a time and leave in order, delayed by half the
// window (hf, with a default window size of 9). For an input word with a full
// window behind it, the result waits on the single read port of the window
// line memory: the histogram scan reads one bin per cycle and the count update
// pipeline must drain before the mode is loaded. An edge bin reads the center
// bin and then loads it, a pass-through bin is loaded directly, and a flush
// sets its counter, then reads and emits each held bin in turn. The block takes
// one word at a time; the next word is accepted once the current one's last
// result, if it has one, sits in the output register. No clearing pass is needed after reset.
// ============================================================================
module sliding_mode_filter #(
    parameter int NUM_CLASSES     = 16,
    parameter int MAX_HALF_WINDOW = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [smf_pkg::SIZE_W-1:0] cfg_data,      // window_size
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,  // [7:0] class_code
    input  logic                       s_axis_tlast,  // last_bin
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,  // [7:0] bin_class
    output logic                       m_axis_tlast   // last_out
);

    smf_pkg::cmd_t cmd;
    smf_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    smf_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    smf_datapath #(
        .NUM_CLASSES     (NUM_CLASSES),
        .MAX_HALF_WINDOW (MAX_HALF_WINDOW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_data  (cfg_data),
        .in_code   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .out_code  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: sliding_mode_filter bench
// Drives radials of class codes through the stream ports under several window
// sizes, predicts every output bin from a local model of the window filter and
// compares each output word field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

localparam int TB_CLASSES = 16;
localparam int HALF_MAX   = 8;
localparam int LINE_LEN   = 2 * HALF_MAX + 1;

typedef struct packed {
    logic [7:0] code;
    logic       last;
} out_bin_t;

class smf_scoreboard;
    logic [7:0]  recent_codes [LINE_LEN];
    int unsigned radial_fill;
    logic [4:0]  window_size;
    int unsigned hist [TB_CLASSES];
    logic [7:0]  best_code;
    int unsigned best_count;
    out_bin_t    pending_bins [$];
    int unsigned errors;

    function new();
        window_size = smf_pkg::WINDOW_SIZE_RESET;
        radial_fill = 0;
        errors = 0;
        foreach (recent_codes[k])
            recent_codes[k] = '0;
    endfunction

    function void set_window(logic [4:0] value);
        window_size = value;
    endfunction

    task report(string msg);
        errors++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // codes outside the class range never enter the histogram
    function void tally(logic [7:0] code);
        if (code < TB_CLASSES)
        begin
            hist[code]++;
            if (hist[code] >= best_count)
            begin
                best_code  = code;
                best_count = hist[code];
            end
        end
    endfunction

    // Outer bins first, center last, so a tie goes to the nearest occurrence
    // and the older side wins at equal distance.
    function logic [7:0] majority_code(int unsigned hf);
        int unsigned d;
        foreach (hist[k])
            hist[k] = 0;
        best_code  = '0;
        best_count = 0;
        for (d = hf; d > 0; d--)
        begin
            tally(recent_codes[hf - d]);
            tally(recent_codes[hf + d]);
        end
        tally(recent_codes[hf]);
        return best_code;
    endfunction

    function void note_bin(logic [7:0] code, logic last);
        int unsigned hf;
        int unsigned held;
        int unsigned k;
        int unsigned made;
        out_bin_t    item;
        hf = 32'(window_size) >> 1;
        if (hf > HALF_MAX)
            hf = HALF_MAX;
        if (hf == 0)
        begin
            radial_fill = 0;
            item.code = code;
            item.last = last;
            pending_bins.push_back(item);
            return;
        end
        for (k = LINE_LEN - 1; k > 0; k--)
            recent_codes[k] = recent_codes[k - 1];
        recent_codes[0] = code;
        if (radial_fill < LINE_LEN)
            radial_fill++;
        made = 0;
        if (radial_fill > hf)
        begin
            item.code = (radial_fill >= 2 * hf + 1) ? majority_code(hf) : recent_codes[hf];
            item.last = 1'b0;
            pending_bins.push_back(item);
            made++;
        end
        if (last)
        begin
            // flush the bins still held, oldest first
            held = (radial_fill < hf) ? radial_fill : hf;
            for (k = held; k > 0; k--)
            begin
                item.code = recent_codes[k - 1];
                item.last = 1'b0;
                pending_bins.push_back(item);
                made++;
            end
            if (made > 0)
                pending_bins[pending_bins.size() - 1].last = 1'b1;
            radial_fill = 0;
        end
    endfunction

    task check_bin(logic [7:0] code, logic last);
        out_bin_t want;
        if (pending_bins.size() == 0)
        begin
            report($sformatf("unexpected word bin_class=%0d last_out=%0b", $signed(code), last));
            return;
        end
        want = pending_bins.pop_front();
        if (code !== want.code)
            report($sformatf("bin_class %0d, want %0d", $signed(code), $signed(want.code)));
        if (last !== want.last)
            report($sformatf("last_out %0b, want %0b", last, want.last));
    endtask
endclass

module tb_top;

    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYC  = 80;
    localparam int HOLD_CYC    = 400;
    localparam int PHASE_BINS  = 48;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [smf_pkg::SIZE_W-1:0] cfg_data;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [7:0]                 s_axis_tdata;   // [7:0] class_code
    logic                       s_axis_tlast;   // last_bin
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [7:0]                 m_axis_tdata;   // [7:0] bin_class
    logic                       m_axis_tlast;   // last_out

    smf_scoreboard sb;
    bit            no_idle;
    bit            hold_done;
    int unsigned   results_seen;
    int unsigned   stall_cycles;

    logic [7:0] first_radial [12] = '{8'd0, 8'd15, 8'd16, 8'hFF, 8'd127, 8'h80,
                                      8'd3, 8'd3, 8'd5, 8'd5, 8'd7, 8'd7};
    int         phase_sizes [9] = '{17, 0, 2, 9, 16, 1, -1, 5, -1};

    sliding_mode_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    // Call at a falling edge; returns at the falling edge after acceptance
    // with tvalid still high, so back-to-back words need no extra toggle.
    task send_bin(input logic [7:0] code, input logic last);
        while (!no_idle && $urandom_range(0, 99) < 29)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_bin(code, last);
        @(negedge clk);
    endtask

    // drop the input, drain every expected word, then let held work finish
    task settle(input int cycles);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_bins.size() != 0)
            @(negedge clk);
        repeat (cycles) @(negedge clk);
    endtask

    task write_window(input logic [4:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_window(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function logic [7:0] pick_code();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 8'($urandom_range(0, 3));
        else if (r < 80)
            return 8'($urandom_range(0, TB_CLASSES - 1));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    task random_radials(input int budget);
        int unsigned sent;
        int unsigned len;
        int unsigned i;
        int unsigned r;
        logic        last;
        sent = 0;
        while (sent < budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                len = $urandom_range(1, 24);
            else if (r < 90)
                len = $urandom_range(25, 45);
            else
                len = $urandom_range(1, 3);
            // end the radial at the budget
            if (len > budget - sent)
                len = budget - sent;
            for (i = 0; i < len; i++)
            begin
                last = (i == len - 1);
                // break a radial now and then
                if (!last && $urandom_range(0, 99) < 2)
                    last = 1'b1;
                send_bin(pick_code(), last);
                sent++;
            end
        end
    endtask

    // output side: random ready, one long hold-off once traffic is flowing
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= 150)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYC) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 29);
            end
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            sb.check_bin(m_axis_tdata, m_axis_tlast);
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !rst_n)
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("sliding_mode_filter verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int p;
        int size;
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        no_idle       = 1'b0;
        hold_done     = 1'b0;
        results_seen  = 0;
        stall_cycles  = 0;
        sb = new();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset size: full windows with ties, invalid and extreme codes
        foreach (first_radial[k])
            send_bin(first_radial[k], k == 11);
        // radial shorter than the window, then a one-bin radial
        send_bin(8'd2, 1'b0);
        send_bin(8'd2, 1'b0);
        send_bin(8'd1, 1'b0);
        send_bin(8'd2, 1'b1);
        send_bin(8'd9, 1'b1);
        settle(SETTLE_CYC);

        // pass-through sizes
        write_window(5'd0);
        send_bin(8'h80, 1'b0);
        send_bin(8'd127, 1'b1);
        send_bin(8'd4, 1'b0);
        settle(SETTLE_CYC);
        write_window(5'd1);
        send_bin(8'hFF, 1'b1);
        send_bin(8'd0, 1'b0);
        settle(SETTLE_CYC);

        // window of nothing but invalid codes, then resize mid-radial
        write_window(5'd3);
        send_bin(8'd20, 1'b0);
        send_bin(8'hFB, 1'b0);
        send_bin(8'd100, 1'b0);
        settle(SETTLE_CYC);
        write_window(5'd5);
        send_bin(8'd6, 1'b0);
        send_bin(8'd6, 1'b0);
        send_bin(8'd6, 1'b1);
        settle(SETTLE_CYC);

        for (p = 0; p < 9; p++)
        begin
            size = (phase_sizes[p] < 0) ? $urandom_range(0, 17) : phase_sizes[p];
            write_window(size[4:0]);
            no_idle = (p == 3);
            random_radials(PHASE_BINS);
            settle(SETTLE_CYC);
        end
        no_idle = 1'b0;

        settle(100);
        while (sb.pending_bins.size() != 0)
        begin
            sb.report("expected word never arrived");
            void'(sb.pending_bins.pop_front());
        end
        if (sb.errors == 0)
            $display("sliding_mode_filter verification clean");
        else
            $display("sliding_mode_filter verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/smf_pkg.sv
rtl/smf_ctrl.sv
rtl/smf_datapath.sv
rtl/sliding_mode_filter.sv
bench/tb_top.sv
